// ===== design/oba_pkg.sv =====
`default_nettype none

package oba_pkg;

    // Datapath widths.
    localparam int PRICE_BITS    = 32;
    localparam int TIME_BITS     = 48;
    localparam int VOL_BITS      = 32;
    localparam int PERIOD_BITS   = 40;
    localparam int CFG_DATA_BITS = 48;
    localparam int CFG_IDX_BITS  = 3;

    typedef logic signed [PRICE_BITS-1:0] price_t;
    typedef logic [TIME_BITS-1:0]         tstamp_t;
    typedef logic [VOL_BITS-1:0]          vol_t;
    typedef logic [PERIOD_BITS-1:0]       period_t;
    typedef logic [CFG_DATA_BITS-1:0]     cfg_data_t;
    typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_BAR_PERIOD       = 3'd0;
    localparam cfg_idx_t CFG_EPOCH_LENGTH     = 3'd1;
    localparam cfg_idx_t CFG_FIRST_BAR_TIME   = 3'd2;
    localparam cfg_idx_t CFG_FIRST_EPOCH_TIME = 3'd3;
    localparam cfg_idx_t CFG_BAR_CAPACITY     = 3'd4;

    // Reset values of the configuration registers.
    localparam period_t RST_BAR_PERIOD   = 40'd60000;
    localparam period_t RST_EPOCH_LENGTH = 40'd86400000;

    typedef struct packed {
        logic      valid;
        cfg_idx_t  index;
        cfg_data_t data;
    } cfg_wr_t;

    typedef struct packed {
        tstamp_t item_time;
        logic    source_is_candle;
        price_t  open_price;
        price_t  high_price;
        price_t  low_price;
        price_t  close_price;
        vol_t    tick_count;
        vol_t    ask_amount;
        vol_t    bid_amount;
        price_t  spread_value;
    } item_t;

    typedef struct packed {
        tstamp_t bar_time;
        price_t  bar_open;
        price_t  bar_high;
        price_t  bar_low;
        price_t  bar_close;
        vol_t    bar_ticks;
        vol_t    bar_ask;
        vol_t    bar_bid;
        price_t  bar_spread;
        logic    is_ghost_bar;
        vol_t    bars_held;
    } result_t;

    // Saturating volume sum.
    function automatic vol_t sat_add(input vol_t a, input vol_t b);
        logic [VOL_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VOL_BITS] ? {VOL_BITS{1'b1}} : s[VOL_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/oba_in_reg.sv =====
`default_nettype none

module oba_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire oba_pkg::item_t in_item,
    input  wire logic           take,
    output logic                item_valid,
    output oba_pkg::item_t      item
);
    import oba_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // The slot can refill in the same cycle that its item moves on.
    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== design/oba_bar_core.sv =====
`default_nettype none

module oba_bar_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire oba_pkg::cfg_wr_t cfg,
    input  wire oba_pkg::item_t   item,
    input  wire logic             fire,
    output logic                  has_result,
    output oba_pkg::result_t      result
);
    import oba_pkg::*;

    // Configuration.
    period_t bar_period_reg;
    period_t epoch_length_reg;
    vol_t    bar_capacity_reg;

    // Bar state.
    tstamp_t next_boundary_reg, next_boundary_next;
    tstamp_t next_epoch_reg, next_epoch_next;
    tstamp_t open_bar_time_reg, open_bar_time_next;
    price_t  acc_open_reg, acc_open_next;
    price_t  acc_high_reg, acc_high_next;
    price_t  acc_low_reg, acc_low_next;
    price_t  acc_close_reg, acc_close_next;
    vol_t    acc_ticks_reg, acc_ticks_next;
    vol_t    acc_ask_reg, acc_ask_next;
    vol_t    acc_bid_reg, acc_bid_next;
    price_t  acc_spread_reg, acc_spread_next;
    vol_t    closed_count_reg, closed_count_next;

    // Item view: for a tick the close price stands in for open, high and low.
    price_t  it_open, it_high, it_low;
    logic    upd, cls;

    // Bar after the update step.
    price_t  u_open, u_high, u_low, u_close, u_spread;
    vol_t    u_ticks, u_ask, u_bid;

    // Boundary arithmetic.
    tstamp_t period_ext, epoch_ext, nb_adv, ne_lim;

    assign it_open = item.source_is_candle ? item.open_price : item.close_price;
    assign it_high = item.source_is_candle ? item.high_price : item.close_price;
    assign it_low  = item.source_is_candle ? item.low_price  : item.close_price;

    // A source bar exactly on the boundary both updates and closes the bar.
    assign upd = item.source_is_candle ? (item.item_time <= next_boundary_reg)
                                       : (item.item_time <  next_boundary_reg);
    assign cls = (item.item_time >= next_boundary_reg);

    always_comb
    begin
        u_open   = acc_open_reg;
        u_high   = acc_high_reg;
        u_low    = acc_low_reg;
        u_close  = acc_close_reg;
        u_ticks  = acc_ticks_reg;
        u_ask    = acc_ask_reg;
        u_bid    = acc_bid_reg;
        u_spread = acc_spread_reg;
        if (upd)
        begin
            if (acc_ticks_reg != '0)
            begin
                if (it_high > acc_high_reg)
                begin
                    u_high = it_high;
                end
                if (it_low < acc_low_reg)
                begin
                    u_low = it_low;
                end
                u_close = item.close_price;
                u_ticks = sat_add(acc_ticks_reg, item.tick_count);
                u_ask   = sat_add(acc_ask_reg, item.ask_amount);
                u_bid   = sat_add(acc_bid_reg, item.bid_amount);
                if (item.spread_value > acc_spread_reg)
                begin
                    u_spread = item.spread_value;
                end
            end
            else
            begin
                u_open   = it_open;
                u_high   = it_high;
                u_low    = it_low;
                u_close  = item.close_price;
                u_ticks  = item.tick_count;
                u_ask    = item.ask_amount;
                u_bid    = item.bid_amount;
                u_spread = item.spread_value;
            end
        end
    end

    // Closed bar.
    always_comb
    begin
        closed_count_next = closed_count_reg;
        if (closed_count_reg < bar_capacity_reg)
        begin
            closed_count_next = closed_count_reg + 1'b1;
        end

        result.bar_time  = open_bar_time_reg;
        result.bars_held = closed_count_next;
        if (u_ticks != '0)
        begin
            result.bar_open     = u_open;
            result.bar_high     = u_high;
            result.bar_low      = u_low;
            result.bar_close    = u_close;
            result.bar_ticks    = u_ticks;
            result.bar_ask      = u_ask;
            result.bar_bid      = u_bid;
            result.bar_spread   = u_spread;
            result.is_ghost_bar = 1'b0;
        end
        else
        begin
            result.bar_open     = item.close_price;
            result.bar_high     = item.close_price;
            result.bar_low      = item.close_price;
            result.bar_close    = item.close_price;
            result.bar_ticks    = '0;
            result.bar_ask      = '0;
            result.bar_bid      = '0;
            result.bar_spread   = item.spread_value;
            result.is_ghost_bar = 1'b1;
        end
    end

    assign has_result = cls;

    // Next boundary, realigned to the epoch when the epoch is crossed.
    assign period_ext = tstamp_t'(bar_period_reg);
    assign epoch_ext  = tstamp_t'(epoch_length_reg);
    assign nb_adv     = next_boundary_reg + period_ext;
    assign ne_lim     = next_epoch_reg + period_ext;

    always_comb
    begin
        open_bar_time_next = open_bar_time_reg;
        next_boundary_next = next_boundary_reg;
        next_epoch_next    = next_epoch_reg;
        acc_open_next      = u_open;
        acc_high_next      = u_high;
        acc_low_next       = u_low;
        acc_close_next     = u_close;
        acc_ticks_next     = u_ticks;
        acc_ask_next       = u_ask;
        acc_bid_next       = u_bid;
        acc_spread_next    = u_spread;
        if (cls)
        begin
            open_bar_time_next = next_boundary_reg;
            if (item.tick_count == '0)
            begin
                // A ghost item opens an empty bar and leaves the prices alone.
                acc_ticks_next = '0;
            end
            else
            begin
                acc_open_next   = it_open;
                acc_high_next   = it_high;
                acc_low_next    = it_low;
                acc_close_next  = item.close_price;
                acc_ticks_next  = item.tick_count;
                acc_ask_next    = item.ask_amount;
                acc_bid_next    = item.bid_amount;
                acc_spread_next = item.spread_value;
            end
            next_boundary_next = nb_adv;
            if (nb_adv > next_epoch_reg)
            begin
                if (nb_adv < ne_lim)
                begin
                    next_boundary_next = ne_lim;
                end
                next_epoch_next = next_epoch_reg + epoch_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_period_reg    <= RST_BAR_PERIOD;
            epoch_length_reg  <= RST_EPOCH_LENGTH;
            bar_capacity_reg  <= '0;
            next_boundary_reg <= '0;
            next_epoch_reg    <= '0;
            open_bar_time_reg <= '0;
            acc_open_reg      <= '0;
            acc_high_reg      <= '0;
            acc_low_reg       <= '0;
            acc_close_reg     <= '0;
            acc_ticks_reg     <= '0;
            acc_ask_reg       <= '0;
            acc_bid_reg       <= '0;
            acc_spread_reg    <= '0;
            closed_count_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                open_bar_time_reg <= open_bar_time_next;
                next_boundary_reg <= next_boundary_next;
                next_epoch_reg    <= next_epoch_next;
                acc_open_reg      <= acc_open_next;
                acc_high_reg      <= acc_high_next;
                acc_low_reg       <= acc_low_next;
                acc_close_reg     <= acc_close_next;
                acc_ticks_reg     <= acc_ticks_next;
                acc_ask_reg       <= acc_ask_next;
                acc_bid_reg       <= acc_bid_next;
                acc_spread_reg    <= acc_spread_next;
                if (cls)
                begin
                    closed_count_reg <= closed_count_next;
                end
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_BAR_PERIOD:       bar_period_reg    <= cfg.data[PERIOD_BITS-1:0];
                    CFG_EPOCH_LENGTH:     epoch_length_reg  <= cfg.data[PERIOD_BITS-1:0];
                    CFG_FIRST_BAR_TIME:   next_boundary_reg <= tstamp_t'(cfg.data);
                    CFG_FIRST_EPOCH_TIME: next_epoch_reg    <= tstamp_t'(cfg.data);
                    CFG_BAR_CAPACITY:     bar_capacity_reg  <= cfg.data[VOL_BITS-1:0];
                    default:              ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/oba_out_reg.sv =====
`default_nettype none

module oba_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire oba_pkg::result_t load_data,
    output logic                  slot_free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output oba_pkg::result_t      data
);
    import oba_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Free when empty or when the held bar leaves this cycle.
    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign data      = data_reg;

endmodule

`default_nettype wire

// ===== design/ohlc_bar_aggregator.sv =====
// Time-bar aggregator for a market data stream.
// Ticks or finer source bars come in on the input channel (in_valid/in_ready),
// one per transfer. Each closed bar leaves on the output channel
// (out_valid/out_ready) as one transfer; an item that does not cross the bar
// boundary produces no output transfer.
// Configuration goes through cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Writes are to be made only while the block is
// idle; the block itself does not enforce this. An accepted item waits in the
// input register until the output register can take the bar it may close; it
// is then processed, and its bar, if any, is presented from the output register.
// Throughput: one item per cycle while the receiver keeps taking bars; the bar
// state update is a single pass of compares, 32-bit volume adds and 48-bit
// boundary adds between the input register and the result register.
// When the receiver stalls, the held bar waits in the output register, one
// more item waits in the input register, and in_ready then drops.
// Reset clears the open bar, the boundaries and the closed-bar count and loads
// the default bar period (one minute) and epoch length (one day).

`default_nettype none

module ohlc_bar_aggregator (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire oba_pkg::cfg_idx_t  cfg_index,
    input  wire oba_pkg::cfg_data_t cfg_data,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire oba_pkg::tstamp_t   item_time,
    input  wire logic               source_is_candle,
    input  wire oba_pkg::price_t    open_price,
    input  wire oba_pkg::price_t    high_price,
    input  wire oba_pkg::price_t    low_price,
    input  wire oba_pkg::price_t    close_price,
    input  wire oba_pkg::vol_t      tick_count,
    input  wire oba_pkg::vol_t      ask_amount,
    input  wire oba_pkg::vol_t      bid_amount,
    input  wire oba_pkg::price_t    spread_value,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output oba_pkg::tstamp_t        bar_time,
    output oba_pkg::price_t         bar_open,
    output oba_pkg::price_t         bar_high,
    output oba_pkg::price_t         bar_low,
    output oba_pkg::price_t         bar_close,
    output oba_pkg::vol_t           bar_ticks,
    output oba_pkg::vol_t           bar_ask,
    output oba_pkg::vol_t           bar_bid,
    output oba_pkg::price_t         bar_spread,
    output logic                    is_ghost_bar,
    output oba_pkg::vol_t           bars_held
);
    import oba_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    cfg_wr_t cfg;
    logic    fire;
    logic    slot_free;
    logic    has_result;
    result_t core_result;
    result_t out_data;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign in_item.item_time        = item_time;
    assign in_item.source_is_candle = source_is_candle;
    assign in_item.open_price       = open_price;
    assign in_item.high_price       = high_price;
    assign in_item.low_price        = low_price;
    assign in_item.close_price      = close_price;
    assign in_item.tick_count       = tick_count;
    assign in_item.ask_amount       = ask_amount;
    assign in_item.bid_amount       = bid_amount;
    assign in_item.spread_value     = spread_value;

    // The held item is processed only when the output register can take
    // whatever bar it may close, so no result is ever dropped.
    assign fire = item_valid && slot_free;

    oba_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    oba_bar_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .fire       (fire),
        .has_result (has_result),
        .result     (core_result)
    );

    oba_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire && has_result),
        .load_data  (core_result),
        .slot_free  (slot_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data       (out_data)
    );

    assign bar_time     = out_data.bar_time;
    assign bar_open     = out_data.bar_open;
    assign bar_high     = out_data.bar_high;
    assign bar_low      = out_data.bar_low;
    assign bar_close    = out_data.bar_close;
    assign bar_ticks    = out_data.bar_ticks;
    assign bar_ask      = out_data.bar_ask;
    assign bar_bid      = out_data.bar_bid;
    assign bar_spread   = out_data.bar_spread;
    assign is_ghost_bar = out_data.is_ghost_bar;
    assign bars_held    = out_data.bars_held;

endmodule

`default_nettype wire

// ===== tb/sv/ohlc_bar_aggregator_tb.sv =====
`default_nettype none

// Self-checking bench for the OHLC bar aggregator.
// A behavioral copy of the bar logic runs beside the block. Every item the block
// takes is folded into that copy, and any bar it closes is queued. Each bar the
// block hands out is popped from that queue and compared field by field.
module ohlc_bar_aggregator_tb;

    import oba_pkg::*;

    // Share of cycles in which each side holds back.
    localparam int IDLE_PCT = 23;
    // Cycles to let pass after the last expected bar before a register write.
    localparam int SETTLE_CYCLES = 4;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Only this many failures are printed in full.
    localparam int REPORT_MAX = 10;

    localparam price_t PRICE_MAX = {1'b0, {(PRICE_BITS-1){1'b1}}};
    localparam price_t PRICE_MIN = {1'b1, {(PRICE_BITS-1){1'b0}}};
    localparam vol_t   VOL_MAX   = '1;
    localparam tstamp_t TIME_MAX = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    cfg_idx_t  cfg_index = '0;
    cfg_data_t cfg_data = '0;

    logic    in_valid = 1'b0;
    logic    in_ready;
    tstamp_t item_time = '0;
    logic    source_is_candle = 1'b0;
    price_t  open_price = '0;
    price_t  high_price = '0;
    price_t  low_price = '0;
    price_t  close_price = '0;
    vol_t    tick_count = '0;
    vol_t    ask_amount = '0;
    vol_t    bid_amount = '0;
    price_t  spread_value = '0;

    logic    out_valid;
    logic    out_ready = 1'b0;
    tstamp_t bar_time;
    price_t  bar_open;
    price_t  bar_high;
    price_t  bar_low;
    price_t  bar_close;
    vol_t    bar_ticks;
    vol_t    bar_ask;
    vol_t    bar_bid;
    price_t  bar_spread;
    logic    is_ghost_bar;
    vol_t    bars_held;

    ohlc_bar_aggregator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .item_time        (item_time),
        .source_is_candle (source_is_candle),
        .open_price       (open_price),
        .high_price       (high_price),
        .low_price        (low_price),
        .close_price      (close_price),
        .tick_count       (tick_count),
        .ask_amount       (ask_amount),
        .bid_amount       (bid_amount),
        .spread_value     (spread_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .bar_time         (bar_time),
        .bar_open         (bar_open),
        .bar_high         (bar_high),
        .bar_low          (bar_low),
        .bar_close        (bar_close),
        .bar_ticks        (bar_ticks),
        .bar_ask          (bar_ask),
        .bar_bid          (bar_bid),
        .bar_spread       (bar_spread),
        .is_ghost_bar     (is_ghost_bar),
        .bars_held        (bars_held)
    );

    // Register mirror, loaded with the reset values of the block.
    period_t cfg_period = RST_BAR_PERIOD;
    period_t cfg_epoch = RST_EPOCH_LENGTH;
    vol_t    cfg_capacity = '0;

    // Mirror of the bar state. Prices are kept signed, so plain compares order them.
    tstamp_t next_bar_edge = '0;
    tstamp_t next_epoch_edge = '0;
    tstamp_t open_start = '0;
    price_t  run_open = '0;
    price_t  run_high = '0;
    price_t  run_low = '0;
    price_t  run_close = '0;
    vol_t    run_ticks = '0;
    vol_t    run_ask = '0;
    vol_t    run_bid = '0;
    price_t  run_spread = '0;
    vol_t    closed_bars = '0;

    // Bars the block still owes, oldest first.
    result_t pending_bars[$];

    int   fail_count = 0;
    int   items_sent = 0;
    int   candles_sent = 0;
    int   bars_checked = 0;
    int   ghost_bars = 0;
    int   reg_writes = 0;
    int   quiet_cycles = 0;
    logic steady = 1'b0;
    price_t price_anchor = 100000;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Bar prediction
    // ------------------------------------------------------------------

    function automatic vol_t vol_sum(input vol_t a, input vol_t b);
        // The sum overflows exactly when a exceeds the headroom left above b.
        return (a > ~b) ? VOL_MAX : vol_t'(a + b);
    endfunction

    function automatic void mirror_cfg_write(input cfg_idx_t idx, input cfg_data_t value);
        case (idx)
            CFG_BAR_PERIOD:       cfg_period = period_t'(value);
            CFG_EPOCH_LENGTH:     cfg_epoch = period_t'(value);
            CFG_FIRST_BAR_TIME:   next_bar_edge = tstamp_t'(value);
            CFG_FIRST_EPOCH_TIME: next_epoch_edge = tstamp_t'(value);
            CFG_BAR_CAPACITY:     cfg_capacity = vol_t'(value);
            default:              ;
        endcase
    endfunction

    function automatic void start_bar(input item_t it, input price_t o, input price_t h,
                                      input price_t l);
        run_open = o;
        run_high = h;
        run_low = l;
        run_close = it.close_price;
        run_ticks = it.tick_count;
        run_ask = it.ask_amount;
        run_bid = it.bid_amount;
        run_spread = it.spread_value;
    endfunction

    // Folds one accepted item into the mirror and queues the bar it closes, if any.
    function automatic void fold_item(input item_t it);
        price_t  o;
        price_t  h;
        price_t  l;
        logic    take;
        logic    close_now;
        tstamp_t floor_edge;
        result_t bar;

        // A tick stands in its close price for open, high and low.
        o = it.source_is_candle ? it.open_price : it.close_price;
        h = it.source_is_candle ? it.high_price : it.close_price;
        l = it.source_is_candle ? it.low_price : it.close_price;

        // A source bar sitting exactly on the boundary both updates and closes.
        take = it.source_is_candle ? (it.item_time <= next_bar_edge)
                                   : (it.item_time < next_bar_edge);
        close_now = it.source_is_candle ? (it.item_time >= next_bar_edge) : !take;

        if (take)
        begin
            if (run_ticks != '0)
            begin
                if (h > run_high)
                    run_high = h;
                if (l < run_low)
                    run_low = l;
                run_close = it.close_price;
                run_ticks = vol_sum(run_ticks, it.tick_count);
                run_ask = vol_sum(run_ask, it.ask_amount);
                run_bid = vol_sum(run_bid, it.bid_amount);
                if (it.spread_value > run_spread)
                    run_spread = it.spread_value;
            end
            else
            begin
                start_bar(it, o, h, l);
            end
        end

        if (close_now)
        begin
            bar.bar_time = open_start;
            if (run_ticks != '0)
            begin
                bar.bar_open = run_open;
                bar.bar_high = run_high;
                bar.bar_low = run_low;
                bar.bar_close = run_close;
                bar.bar_ticks = run_ticks;
                bar.bar_ask = run_ask;
                bar.bar_bid = run_bid;
                bar.bar_spread = run_spread;
                bar.is_ghost_bar = 1'b0;
            end
            else
            begin
                // An empty bar is flat at the closing item's price.
                bar.bar_open = it.close_price;
                bar.bar_high = it.close_price;
                bar.bar_low = it.close_price;
                bar.bar_close = it.close_price;
                bar.bar_ticks = '0;
                bar.bar_ask = '0;
                bar.bar_bid = '0;
                bar.bar_spread = it.spread_value;
                bar.is_ghost_bar = 1'b1;
            end
            if (closed_bars < cfg_capacity)
                closed_bars = closed_bars + 1'b1;
            bar.bars_held = closed_bars;
            pending_bars.push_back(bar);

            // A ghost item only empties the new bar; anything else seeds it.
            open_start = next_bar_edge;
            if (it.tick_count == '0)
                run_ticks = '0;
            else
                start_bar(it, o, h, l);

            // Step the boundary and realign it when it runs past the epoch.
            next_bar_edge = next_bar_edge + tstamp_t'(cfg_period);
            if (next_bar_edge > next_epoch_edge)
            begin
                floor_edge = next_epoch_edge + tstamp_t'(cfg_period);
                if (next_bar_edge < floor_edge)
                    next_bar_edge = floor_edge;
                next_epoch_edge = next_epoch_edge + tstamp_t'(cfg_epoch);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
            report_failure($sformatf("bar %0d field %s: expected %0h, got %0h",
                                     bars_checked, name, want, got));
    endfunction

    // Each output transfer is matched against the oldest bar still owed.
    always @(posedge clk)
    begin : bar_checker
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bars.size() == 0)
            begin
                report_failure($sformatf("bar at time %0h arrived with none expected",
                                         bar_time));
            end
            else
            begin
                want = pending_bars.pop_front();
                check_field("bar_time", want.bar_time, bar_time);
                check_field("bar_open", want.bar_open, bar_open);
                check_field("bar_high", want.bar_high, bar_high);
                check_field("bar_low", want.bar_low, bar_low);
                check_field("bar_close", want.bar_close, bar_close);
                check_field("bar_ticks", want.bar_ticks, bar_ticks);
                check_field("bar_ask", want.bar_ask, bar_ask);
                check_field("bar_bid", want.bar_bid, bar_bid);
                check_field("bar_spread", want.bar_spread, bar_spread);
                check_field("is_ghost_bar", want.is_ghost_bar, is_ghost_bar);
                check_field("bars_held", want.bars_held, bars_held);
                if (want.is_ghost_bar)
                    ghost_bars++;
                bars_checked++;
            end
        end
    end

    // The receiver holds back at random, except during the steady stretch.
    always @(negedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // A run in which no channel moves for too long is declared hung.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles, %0d bars still owed",
                     quiet_cycles, pending_bars.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Writes one register. The write channel is lowered on the following falling edge.
    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        mirror_cfg_write(idx, value);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Offers one item, with a random gap in front of it, and holds it until it is taken.
    task automatic send_item(input item_t it);
        @(negedge clk);
        while (!steady && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        item_time <= it.item_time;
        source_is_candle <= it.source_is_candle;
        open_price <= it.open_price;
        high_price <= it.high_price;
        low_price <= it.low_price;
        close_price <= it.close_price;
        tick_count <= it.tick_count;
        ask_amount <= it.ask_amount;
        bid_amount <= it.bid_amount;
        spread_value <= it.spread_value;
        do
            @(posedge clk);
        while (!in_ready);
        fold_item(it);
        items_sent++;
        if (it.source_is_candle)
            candles_sent++;
    endtask

    // Stops offering items and waits until every owed bar has been delivered.
    // An item that closes nothing may still be in the pipe, hence the settle time.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Item generation
    // ------------------------------------------------------------------

    function automatic item_t make_tick(input tstamp_t t, input price_t px, input vol_t tk,
                                        input vol_t ak, input vol_t bd, input price_t sp);
        item_t it;
        // Open, high and low carry noise: a tick must ignore them.
        it.item_time = t;
        it.source_is_candle = 1'b0;
        it.open_price = $urandom;
        it.high_price = $urandom;
        it.low_price = $urandom;
        it.close_price = px;
        it.tick_count = tk;
        it.ask_amount = ak;
        it.bid_amount = bd;
        it.spread_value = sp;
        return it;
    endfunction

    function automatic item_t make_candle(input tstamp_t t, input price_t o, input price_t h,
                                          input price_t l, input price_t c, input vol_t tk,
                                          input vol_t ak, input vol_t bd, input price_t sp);
        item_t it;
        it = make_tick(t, c, tk, ak, bd, sp);
        it.source_is_candle = 1'b1;
        it.open_price = o;
        it.high_price = h;
        it.low_price = l;
        return it;
    endfunction

    // Mostly prices that wander near an anchor, now and then anything at all.
    function automatic price_t pick_price();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return price_anchor + price_t'($signed($urandom_range(400)) - 200);
        else if (roll < 90)
            return $urandom;
        else if (roll < 95)
            return PRICE_MAX;
        else
            return PRICE_MIN;
    endfunction

    function automatic vol_t pick_volume(input int unsigned zero_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < zero_pct)
            return '0;
        else if (roll < zero_pct + 8)
            return $urandom;
        else if (roll < zero_pct + 12)
            return VOL_MAX - $urandom_range(3);
        else
            return $urandom_range(1, 50);
    endfunction

    // Times cluster around the next boundary so that updates, exact hits and
    // closes all come often; a few land anywhere in the time range.
    function automatic item_t random_item();
        item_t       it;
        int unsigned step;
        int unsigned roll;
        tstamp_t     t;
        price_t      c;

        if (cfg_period == '0)
            step = 1;
        else if (cfg_period > period_t'(32'hFFFF_FFFF))
            step = 32'hFFFF_FFFF;
        else
            step = cfg_period[31:0];

        roll = $urandom_range(99);
        if (roll < 50)
            t = next_bar_edge - tstamp_t'($urandom_range(step, 1));
        else if (roll < 62)
            t = next_bar_edge;
        else if (roll < 90)
            t = next_bar_edge + tstamp_t'($urandom_range(step, 0));
        else if (roll < 95)
            t = next_bar_edge + tstamp_t'(step) * $urandom_range(5, 2);
        else
            t = tstamp_t'({$urandom, $urandom});

        price_anchor = price_anchor + price_t'($signed($urandom_range(200)) - 100);
        c = pick_price();
        if ($urandom_range(99) < 40)
            it = make_candle(t, pick_price(), pick_price(), pick_price(), c,
                             pick_volume(10), pick_volume(5), pick_volume(5), $urandom);
        else
            it = make_tick(t, c, pick_volume(10), pick_volume(5), pick_volume(5),
                           ($urandom_range(99) < 80) ? price_t'($urandom_range(50))
                                                     : price_t'($urandom));
        return it;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            send_item(random_item());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Runs on the reset settings: one-minute bars, one-day epoch, both boundaries at
    // zero and no bar capacity, so bars_held stays at zero throughout.
    task automatic test_directed_cases();
        // The very first item closes the empty bar that reset leaves behind.
        send_item(make_tick(0, 100, 1, 10, 20, 3));
        // Saturating volumes and price and spread extremes inside one bar.
        send_item(make_tick(10, PRICE_MAX, VOL_MAX, VOL_MAX, 1, PRICE_MAX));
        send_item(make_tick(20, PRICE_MIN, 7, 9, VOL_MAX, PRICE_MIN));
        send_item(make_candle(30, PRICE_MIN, PRICE_MAX, 0, -5, 2, 2, 2, 0));
        // A tick exactly on the boundary only closes.
        send_item(make_tick(60000, 55, 3, 4, 5, -1));
        // A source bar exactly on the boundary updates first, then closes.
        send_item(make_candle(120000, 1, 9, -9, 4, 1, 1, 1, 2));
        send_item(make_candle(150000, 8, 3, 12, 6, 2, 3, 4, 7));
        // A source bar past the boundary only closes.
        send_item(make_candle(200000, -3, 20, -20, 5, 6, 6, 6, 1));
        // A ghost tick closes the bar and leaves the next one empty.
        send_item(make_tick(240000, 77, 0, 5, 5, 9));
        // So the next close reports an empty bar at this item's price.
        send_item(make_tick(300000, -77, 4, 1, 2, -8));
        // A ghost tick inside a live bar adds no volume but can move the close and the high.
        send_item(make_tick(300001, 0, 0, 0, 0, PRICE_MIN));
        // Latest possible time, then an earlier one that only updates.
        send_item(make_tick(TIME_MAX, 12, 1, VOL_MAX, VOL_MAX, 0));
        send_item(make_candle(TIME_MAX, PRICE_MAX, PRICE_MAX, PRICE_MIN, PRICE_MIN,
                              VOL_MAX, 0, 0, PRICE_MAX));
        send_item(make_tick(1, -1, 2, 0, 0, -1));
        drain_block();
    endtask

    // Indexes past the last register must not disturb anything.
    task automatic test_unused_registers();
        for (int k = CFG_BAR_CAPACITY + 1; k < (1 << CFG_IDX_BITS); k++)
            write_reg(cfg_idx_t'(k), cfg_data_t'({$urandom, $urandom}));
        run_random(20);
        drain_block();
    endtask

    // With no bar length the boundary never moves, so every later item at or past
    // it closes a bar.
    task automatic test_zero_period();
        write_reg(CFG_BAR_PERIOD, '0);
        write_reg(CFG_FIRST_EPOCH_TIME, 500);
        write_reg(CFG_FIRST_BAR_TIME, 1000);
        send_item(make_tick(999, 10, 1, 1, 1, 1));
        send_item(make_tick(1000, 11, 2, 2, 2, 2));
        send_item(make_tick(1000, 12, 3, 3, 3, 3));
        send_item(make_candle(1000, 5, 15, 1, 13, 1, 1, 1, 4));
        send_item(make_tick(5000, 14, 0, 0, 0, 5));
        send_item(make_tick(10, 15, 1, 1, 1, 6));
        drain_block();
    endtask

    // A bar length that does not divide the epoch, so boundaries get pulled back
    // onto the epoch grid; a small capacity makes the closed-bar count saturate.
    task automatic test_epoch_realign();
        write_reg(CFG_BAR_PERIOD, 1000);
        write_reg(CFG_EPOCH_LENGTH, 3500);
        write_reg(CFG_FIRST_BAR_TIME, 10000);
        write_reg(CFG_FIRST_EPOCH_TIME, 10500);
        write_reg(CFG_BAR_CAPACITY, 5);
        run_random(280);
        drain_block();
    endtask

    // All-ones writes check that each register keeps only its own width; the
    // boundaries sit at the top of the time range so the first boundary step wraps.
    task automatic test_extreme_settings();
        write_reg(CFG_BAR_PERIOD, '1);
        write_reg(CFG_EPOCH_LENGTH, '1);
        write_reg(CFG_FIRST_BAR_TIME, 48'hFFFF_FFFF_F000);
        write_reg(CFG_FIRST_EPOCH_TIME, '1);
        write_reg(CFG_BAR_CAPACITY, '1);
        run_random(90);
        drain_block();
    endtask

    // One-millisecond bars and epochs starting from zero.
    task automatic test_minimal_settings();
        write_reg(CFG_BAR_PERIOD, 1);
        write_reg(CFG_EPOCH_LENGTH, 1);
        write_reg(CFG_FIRST_BAR_TIME, '0);
        write_reg(CFG_FIRST_EPOCH_TIME, '0);
        write_reg(CFG_BAR_CAPACITY, '0);
        run_random(90);
        drain_block();
    endtask

    // Random settings; the third pass runs with no idling on either side.
    task automatic test_random_settings();
        period_t   period;
        cfg_data_t start;
        for (int pass = 0; pass < 4; pass++)
        begin
            period = ($urandom_range(9) == 0) ? period_t'({$urandom, $urandom})
                                              : period_t'($urandom_range(5000, 1));
            start = cfg_data_t'({$urandom, $urandom});
            write_reg(CFG_BAR_PERIOD, period);
            write_reg(CFG_EPOCH_LENGTH, period * $urandom_range(8, 1)
                                        + $urandom_range(period[15:0]));
            write_reg(CFG_FIRST_BAR_TIME, start);
            write_reg(CFG_FIRST_EPOCH_TIME, start + $urandom_range(3 * period[15:0]));
            write_reg(CFG_BAR_CAPACITY, ($urandom_range(1) == 0) ? cfg_data_t'($urandom_range(400))
                                                                 : cfg_data_t'({$urandom,
                                                                                $urandom}));
            steady = (pass == 2);
            run_random(110);
            drain_block();
            steady = 1'b0;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_unused_registers();
        test_zero_period();
        test_epoch_realign();
        test_extreme_settings();
        test_minimal_settings();
        test_random_settings();

        // All items are in and the last drain has already let the pipe settle.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_bars.size() != 0)
            report_failure($sformatf("%0d bars never arrived", pending_bars.size()));

        $display("Sent %0d items (%0d source bars) over %0d register writes.",
                 items_sent, candles_sent, reg_writes);
        $display("Checked %0d closed bars, %0d of them empty; %0d failures.",
                 bars_checked, ghost_bars, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/oba_pkg.sv
design/oba_in_reg.sv
design/oba_bar_core.sv
design/oba_out_reg.sv
design/ohlc_bar_aggregator.sv
tb/sv/ohlc_bar_aggregator_tb.sv
